FILE: rtl/core/dsp_pkg.sv
// Shared constants, types and command/status structs for the shortest-path engine.
`default_nettype none

package dsp_pkg;

    // Build-time sizes of the engine.
    localparam int MAX_NODES   = 16;
    localparam int WEIGHT_BITS = 16;

    // Fixed widths of the item and result fields.
    localparam int NODE_W  = 4;
    localparam int WIN_W   = 16;
    localparam int DIST_W  = 20;
    localparam int COUNT_W = 5;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(16);

    // Item command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Derived sizes.
    localparam int IDX_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int WADDR_W    = 2 * IDX_W;
    localparam int WDEPTH     = 1 << WADDR_W;
    localparam int RESULT_CAP = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int CMP_W      = ((IDX_W > NODE_W) ? IDX_W : NODE_W) + 1;
    localparam int SUM_W      = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [DIST_W-1:0]      t_dist;
    typedef logic [WEIGHT_BITS-1:0] t_weight;

    localparam t_dist DIST_INF = {DIST_W{1'b1}};
    localparam t_dist DIST_SAT = DIST_INF - t_dist'(1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_weight;  // write one weight into the matrix memory
        logic init;       // clear the run tables and seed the start node
        logic clr_sel;    // rewind the index and forget the current best node
        logic sel_step;   // examine one node in the least-cost search
        logic mark;       // mark the chosen node visited, rewind the index
        logic rel_step;   // fetch one weight of the chosen node's row
        logic emit;       // load one result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;   // the index is at the last node in use
        logic best_inf;   // the chosen node is unreachable
        logic out_free;   // the output register can take a result this cycle
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/dsp_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module dsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/dsp_ctrl.sv
// Sequencing state machine for loads, search rounds, relaxation and result output.
`default_nettype none

module dsp_ctrl
    import dsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_command,
    input  wire t_idx    i_nm1,
    input  wire t_status i_status,
    output logic         o_stall,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEL   = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_RND   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    logic [2:0] r_state, n_state;
    t_idx       r_round, n_round;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.wr_weight = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_round    = '0;
                        n_state    = S_SEL;
                    end
                end
            end
            S_SEL: begin
                o_cmd.sel_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                // An unreachable pick relaxes nothing.
                n_state = i_status.best_inf ? S_RND : S_REL;
            end
            S_REL: begin
                o_cmd.rel_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.clr_sel = 1'b1;
                if (r_round == i_nm1) begin
                    n_state = S_EMIT;
                end else begin
                    n_round = r_round + t_idx'(1);
                    n_state = S_SEL;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dsp_datapath.sv
// Weight memory, run tables, least-cost search, relaxation and output register.
`default_nettype none

module dsp_datapath
    import dsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire t_idx              i_nm1,
    input  wire logic [NODE_W-1:0] i_row,
    input  wire logic [NODE_W-1:0] i_col,
    input  wire logic [WIN_W-1:0]  i_weight,
    input  wire logic [NODE_W-1:0] i_start_node,
    input  wire logic              i_stall,
    output t_status                o_status,
    output logic                   o_valid,
    output logic [NODE_W-1:0]      o_node,
    output logic [DIST_W-1:0]      o_distance,
    output logic [NODE_W-1:0]      o_parent,
    output logic                   o_has_parent,
    output logic                   o_last
);

    // Run tables.
    t_dist                r_dist   [MAX_NODES];
    t_idx                 r_parent [MAX_NODES];
    logic [MAX_NODES-1:0] r_pvalid;
    logic [MAX_NODES-1:0] r_visited;

    // Scan index, best node so far, and the pending relaxation slot.
    t_idx  r_idx;
    logic  r_found;
    t_idx  r_best_u;
    t_dist r_best_d;
    logic  r_pend;
    t_idx  r_pv;

    // Output register.
    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    t_dist             r_out_dist;
    logic [NODE_W-1:0] r_out_parent;
    logic              r_out_has_parent;
    logic              r_out_last;

    logic               wr_ok;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WADDR_W-1:0] ram_raddr;
    t_weight            ram_rdata;
    t_idx               rd_addr;
    t_dist              rd_dist;
    logic               rd_vis;
    logic [SUM_W-1:0]   sum;
    t_dist              cand;
    logic               relax_ok;
    logic               take;
    logic               start_ok;
    t_idx               start_idx;

    assign wr_ok = i_cmd.wr_weight
                && (CMP_W'(i_row) < CMP_W'(MAX_NODES))
                && (CMP_W'(i_col) < CMP_W'(MAX_NODES));
    assign ram_waddr = {t_idx'(i_row), t_idx'(i_col)};
    assign ram_raddr = {r_best_u, r_idx};

    dsp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (WDEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (ram_waddr),
        .i_wdata (t_weight'(i_weight)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One table read port: the relaxation slot owns it while a weight is in flight.
    assign rd_addr = r_pend ? r_pv : r_idx;
    assign rd_dist = r_dist[rd_addr];
    assign rd_vis  = r_visited[rd_addr];

    assign sum      = SUM_W'(r_best_d) + SUM_W'(ram_rdata);
    assign cand     = (sum >= SUM_W'(DIST_INF)) ? DIST_SAT : t_dist'(sum);
    assign relax_ok = r_pend && (ram_rdata != '0) && !rd_vis && (cand < rd_dist);

    assign take = !rd_vis && (!r_found || (rd_dist < r_best_d));

    assign start_ok  = CMP_W'(i_start_node) <= CMP_W'(i_nm1);
    assign start_idx = t_idx'(i_start_node);

    assign o_status.idx_last = (r_idx == i_nm1);
    assign o_status.best_inf = (r_best_d == DIST_INF);
    assign o_status.out_free = !r_out_valid || !i_stall;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.rel_step;
            if (i_cmd.init || i_cmd.clr_sel || i_cmd.mark) begin
                r_idx <= '0;
            end else if (i_cmd.sel_step || i_cmd.rel_step || i_cmd.emit) begin
                r_idx <= r_idx + t_idx'(1);
            end
            if (i_cmd.init || i_cmd.clr_sel) begin
                r_found <= 1'b0;
            end else if (i_cmd.sel_step && take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tables and payload registers.
    always_ff @(posedge i_clk) begin
        r_pv <= r_idx;
        if (i_cmd.init) begin
            // Only a start node inside the count begins at cost zero.
            for (int i = 0; i < MAX_NODES; i++) begin
                r_dist[i]   <= (start_ok && (start_idx == t_idx'(i))) ? '0 : DIST_INF;
                r_parent[i] <= '0;
            end
            r_pvalid  <= '0;
            r_visited <= '0;
        end else begin
            if (i_cmd.mark) begin
                r_visited[r_best_u] <= 1'b1;
            end
            if (relax_ok) begin
                r_dist[r_pv]   <= cand;
                r_parent[r_pv] <= r_best_u;
                r_pvalid[r_pv] <= 1'b1;
            end
        end
        if (i_cmd.sel_step && take) begin
            r_best_u <= r_idx;
            r_best_d <= rd_dist;
        end
        if (i_cmd.emit) begin
            r_out_node       <= NODE_W'(r_idx);
            r_out_dist       <= rd_dist;
            r_out_parent     <= r_pvalid[r_idx] ? NODE_W'(r_parent[r_idx]) : '0;
            r_out_has_parent <= r_pvalid[r_idx];
            r_out_last       <= (r_idx == i_nm1);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_node       = r_out_node;
    assign o_distance   = r_out_dist;
    assign o_parent     = r_out_parent;
    assign o_has_parent = r_out_has_parent;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/dijkstra_shortest_paths.sv
// Top level of the single-source shortest-path engine over a dense weight matrix.
`default_nettype none

// This block computes single-source shortest paths over a dense adjacency matrix
// of up to 16 nodes. A load item (command 0) writes one 16-bit weight at row and
// column into the matrix memory, where a weight of zero means there is no edge.
// Every entry of the node_count square must be loaded before a run, since
// unwritten entries read back as arbitrary values. A run item (command 1) names
// a start node; the block then performs node_count rounds, each of which scans
// the nodes one per cycle for the least-cost unvisited one (ties go to the lowest
// index), marks the winner visited and then fetches that node's row from the
// matrix memory one weight per cycle to relax its unvisited neighbors. When the
// picked node is unreachable its row is skipped. The row is read through the
// single registered read port of the matrix memory. The rounds are followed by
// one result item per node in use, in node order, one per cycle when the
// receiver does not stall. Each result gives the node, its cost (1048575 for
// unreachable, sums saturate at 1048574), its parent with a has_parent flag,
// and last on the final node. The input stays stalled from the moment a run
// item is accepted until its last result has been taken. The node_count
// register at byte address 0 may only be written while the block is idle;
// 0 acts as 1 and values above 16 act as 16. A start node outside the node
// count leaves every node unreachable.
module dijkstra_shortest_paths
    import dsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Item channel.
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [NODE_W-1:0]  i_row,
    input  wire logic [NODE_W-1:0]  i_col,
    input  wire logic [WIN_W-1:0]   i_weight,
    input  wire logic [NODE_W-1:0]  i_start_node,
    // Result channel.
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [NODE_W-1:0]       o_node,
    output logic [DIST_W-1:0]       o_distance,
    output logic [NODE_W-1:0]       o_parent,
    output logic                    o_has_parent,
    output logic                    o_last,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [COUNT_W-1:0] r_node_count;
    t_idx               nm1;
    t_cmd               cmd;
    t_status            status;
    logic               cfg_wr;
    logic               cfg_hit;

    // The configuration port never inserts wait states. Register index is the
    // word address, so bit 2 of the byte address selects it.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_NODE_COUNT);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? PDATA_W'(r_node_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (cfg_wr) begin
            r_node_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Index of the last node in use, after clamping the register to 1..RESULT_CAP.
    always_comb begin
        if (r_node_count == '0) begin
            nm1 = '0;
        end else if (r_node_count > COUNT_W'(RESULT_CAP)) begin
            nm1 = t_idx'(RESULT_CAP - 1);
        end else begin
            nm1 = t_idx'(r_node_count - COUNT_W'(1));
        end
    end

    dsp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_nm1     (nm1),
        .i_status  (status),
        .o_stall   (o_stall),
        .o_cmd     (cmd)
    );

    dsp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_nm1        (nm1),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_weight     (i_weight),
        .i_start_node (i_start_node),
        .i_stall      (i_stall),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_node       (o_node),
        .o_distance   (o_distance),
        .o_parent     (o_parent),
        .o_has_parent (o_has_parent),
        .o_last       (o_last)
    );

    // Nothing follows the last result of a run once it has been taken.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !i_stall) |=> !o_valid)
        else $error("result presented after the last result of a run");

    // A new item is only taken when no result of an earlier run is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !o_valid)
        else $error("item accepted while a result is still pending");

    // An unreachable node can never have been given a parent.
    a_inf_no_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_distance == DIST_INF)) |-> !o_has_parent)
        else $error("unreachable node reported with a parent");

    // The parent field reads zero whenever there is no parent.
    a_parent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_parent) |-> (o_parent == '0))
        else $error("parent field nonzero without a parent");

endmodule

`default_nettype wire

FILE: dv/tb_dijkstra_shortest_paths.sv
// Self-checking testbench for the dense-matrix shortest-path engine.
`timescale 1ns / 1ps

module tb_dijkstra_shortest_paths;
    import dsp_pkg::*;

    // The run ends if no handshake of any kind completes for this many cycles.
    // The slowest quiet stretch is a 16-node search following the long receiver
    // hold-off, so this leaves a wide margin.
    localparam int unsigned QUIET_LIMIT   = 5000;
    // Cycles allowed after the last result for a trailing load to settle.
    localparam int unsigned SETTLE_CYCLES = 20;
    // Random items issued under each node-count setting, on top of the loads
    // needed to fill the matrix square. The first of them is always a run.
    localparam int unsigned PHASE_ITEMS   = 6;
    // The receiver holds off once for this many cycles, in the middle of a run.
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AFTER    = 40;
    localparam int          PHASES        = 9;
    // Node-count settings, in order: the minimum, zero, a middle value, the
    // maximum, the all-ones code, just above the maximum and a few small ones.
    localparam bit [COUNT_W-1:0] PHASE_COUNTS [PHASES] =
        '{5'd1, 5'd0, 5'd5, 5'd16, 5'd31, 5'd17, 5'd8, 5'd3, 5'd2};
    // Phase with no idling on either side, and phase in which the sender pauses
    // until every outstanding result has been taken.
    localparam int          STEADY_PHASE  = 3;
    localparam int          PAUSE_PHASE   = 5;

    // A small four-node graph for the directed part. Node 0 reaches node 1 both
    // directly and through node 2 at equal cost, nodes 1 and 3 tie for the third
    // pick, node 1 carries a self loop and node 3 has no outgoing edges, so a run
    // from node 3 leaves the rest unreachable even though they have edges.
    localparam bit [WIN_W-1:0] DEMO_GRAPH [4][4] = '{
        '{16'd0, 16'd2, 16'd1, 16'd2},
        '{16'd0, 16'd9, 16'd0, 16'd65535},
        '{16'd0, 16'd1, 16'd0, 16'd65534},
        '{16'd0, 16'd0, 16'd0, 16'd0}
    };

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] parent;
        logic              has_parent;
        logic              last;
    } t_node_result;

    // Keeps a copy of the weight matrix and the node count, solves each run
    // item as it is accepted and checks the node results against the solution.
    class t_path_checker;
        bit [WEIGHT_BITS-1:0] matrix [MAX_NODES][MAX_NODES];
        bit [COUNT_W-1:0]     node_count;
        t_node_result         expected_results [$];
        int unsigned          errors;

        function new();
            node_count = NODE_COUNT_RESET;
            errors     = 0;
        endfunction

        function void set_node_count(bit [COUNT_W-1:0] value);
            node_count = value;
        endfunction

        // Zero counts as one node; anything past the built size is clamped.
        function int active_nodes();
            int n;
            n = (node_count == 0) ? 1 : int'(node_count);
            if (n > MAX_NODES) n = MAX_NODES;
            if (n > RESULT_CAP) n = RESULT_CAP;
            return n;
        endfunction

        function void solve_paths(bit [NODE_W-1:0] start);
            t_dist           cost    [MAX_NODES];
            bit [NODE_W-1:0] via     [MAX_NODES];
            bit              reached [MAX_NODES];
            bit              settled [MAX_NODES];
            bit [DIST_W:0]   cand;
            bit              found;
            int              n;
            int              u;
            t_node_result    res;
            n = active_nodes();
            for (int i = 0; i < MAX_NODES; i++) begin
                cost[i]    = DIST_INF;
                via[i]     = '0;
                reached[i] = 1'b0;
                settled[i] = 1'b0;
            end
            if (start < n) cost[start] = '0;
            for (int pass_no = 0; pass_no < n; pass_no++) begin
                found = 1'b0;
                u     = 0;
                for (int i = 0; i < n; i++) begin
                    if (!settled[i] && (!found || cost[i] < cost[u])) begin
                        u     = i;
                        found = 1'b1;
                    end
                end
                if (!found) break;
                settled[u] = 1'b1;
                // A node still at the infinity code spreads nothing.
                if (cost[u] == DIST_INF) continue;
                for (int v = 0; v < n; v++) begin
                    if (matrix[u][v] == 0 || settled[v]) continue;
                    cand = (DIST_W+1)'(cost[u]) + (DIST_W+1)'(matrix[u][v]);
                    if (cand >= (DIST_W+1)'(DIST_INF)) cand = (DIST_W+1)'(DIST_SAT);
                    if (cand < (DIST_W+1)'(cost[v])) begin
                        cost[v]    = cand[DIST_W-1:0];
                        via[v]     = NODE_W'(u);
                        reached[v] = 1'b1;
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                res.node       = NODE_W'(i);
                res.distance   = cost[i];
                res.parent     = reached[i] ? via[i] : '0;
                res.has_parent = reached[i];
                res.last       = (i == n - 1);
                expected_results.push_back(res);
            end
        endfunction

        function void accept_item(logic cmd, logic [NODE_W-1:0] row, logic [NODE_W-1:0] col,
                                  logic [WIN_W-1:0] weight, logic [NODE_W-1:0] start);
            if (cmd == CMD_LOAD) begin
                if (row < MAX_NODES && col < MAX_NODES)
                    matrix[row][col] = weight[WEIGHT_BITS-1:0];
            end else begin
                solve_paths(start);
            end
        endfunction

        function void check_node_result(t_node_result got);
            t_node_result want;
            if (expected_results.size() == 0) begin
                $error("result for node %0d arrived with none outstanding", got.node);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.node !== want.node) begin
                $error("node: expected %0d, got %0d", want.node, got.node);
                errors++;
            end
            if (got.distance !== want.distance) begin
                $error("distance: expected %0d, got %0d", want.distance, got.distance);
                errors++;
            end
            if (got.parent !== want.parent) begin
                $error("parent: expected %0d, got %0d", want.parent, got.parent);
                errors++;
            end
            if (got.has_parent !== want.has_parent) begin
                $error("has_parent: expected %0b, got %0b", want.has_parent, got.has_parent);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_command;
    logic [NODE_W-1:0]  i_row;
    logic [NODE_W-1:0]  i_col;
    logic [WIN_W-1:0]   i_weight;
    logic [NODE_W-1:0]  i_start_node;
    logic               o_valid;
    logic               i_stall;
    logic [NODE_W-1:0]  o_node;
    logic [DIST_W-1:0]  o_distance;
    logic [NODE_W-1:0]  o_parent;
    logic               o_has_parent;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // When set, neither side inserts random idle cycles.
    bit steady;
    // Matrix entries the stimulus has loaded so far. A run is only issued once
    // the whole square of nodes in use has been loaded, so the block never
    // reads an entry that holds no defined weight.
    bit loaded [MAX_NODES][MAX_NODES];

    t_path_checker route;

    dijkstra_shortest_paths dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_weight     (i_weight),
        .i_start_node (i_start_node),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_node       (o_node),
        .o_distance   (o_distance),
        .o_parent     (o_parent),
        .o_has_parent (o_has_parent),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly sparse graphs with small weights, so that paths of several hops
    // win, with the occasional maximum or fully random weight.
    function automatic logic [WIN_W-1:0] rand_weight();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4) return '0;
        if (pick < 8) return WIN_W'($urandom_range(1, 40));
        if (pick == 8) return '1;
        return WIN_W'($urandom_range(65535));
    endfunction

    // Offers one item and returns at the clock edge where it is accepted. The
    // payload is held until then, and valid is only lowered for random gaps
    // before an item, never while one is being offered.
    task automatic send_item(input logic cmd, input logic [NODE_W-1:0] row,
                             input logic [NODE_W-1:0] col, input logic [WIN_W-1:0] weight,
                             input logic [NODE_W-1:0] start);
        while (!steady && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_row        <= row;
        i_col        <= col;
        i_weight     <= weight;
        i_start_node <= start;
        do @(posedge i_clk); while (o_stall);
        route.accept_item(cmd, row, col, weight, start);
    endtask

    // On a load the start node is a don't-care, so it gets random bits.
    task automatic load_weight(input int unsigned row, input int unsigned col,
                               input logic [WIN_W-1:0] weight);
        loaded[row][col] = 1'b1;
        send_item(CMD_LOAD, NODE_W'(row), NODE_W'(col), weight, NODE_W'($urandom_range(15)));
    endtask

    // On a run the row, column and weight are don't-cares and get random bits.
    task automatic start_run(input int unsigned start);
        send_item(CMD_RUN, NODE_W'($urandom_range(15)), NODE_W'($urandom_range(15)),
                  WIN_W'($urandom_range(65535)), NODE_W'(start));
    endtask

    // Stops offering items until every predicted result has been taken, then
    // lets a trailing load finish before anything else happens.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (route.expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the node count with a setup and an access phase, then reads it
    // back the same way and checks the value returned.
    task automatic write_node_count(input bit [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_NODE_COUNT);
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        route.set_node_count(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PDATA_W'(value)) begin
            $error("node_count readback: expected %0d, got %0d", value, prdata);
            route.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: checks every result taken and stalls at random, once for a
    // long stretch in the middle of a run so that the block backs up and
    // holds off new items while the sender keeps offering them.
    initial begin
        t_node_result got;
        int unsigned  taken;
        int unsigned  hold_left;
        bit           hold_done;
        taken     = 0;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.node       = o_node;
                got.distance   = o_distance;
                got.parent     = o_parent;
                got.has_parent = o_has_parent;
                got.last       = o_last;
                route.check_node_result(got);
                taken++;
                if (!hold_done && taken >= HOLD_AFTER && !o_last) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady && ($urandom_range(99) < 10);
            end
        end
    end

    // Watchdog: any completed handshake, or activity on the register port,
    // restarts the count of quiet cycles.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) quiet = 0;
            else quiet++;
        end
        $display("tb_dijkstra_shortest_paths: errors");
        $finish;
    end

    // Stimulus: reset, a directed pass over a small hand-built graph, then a
    // series of node-count settings, each with a random mix of loads and runs.
    initial begin
        int n;
        route   = new();
        steady  = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= CMD_LOAD;
        i_row        <= '0;
        i_col        <= '0;
        i_weight     <= '0;
        i_start_node <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on four nodes. The extra load in the far corner of the
        // matrix lies outside the square in use and carries the largest weight.
        write_node_count(5'd4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                load_weight(r, c, DEMO_GRAPH[r][c]);
        load_weight(15, 15, '1);
        start_run(0);
        start_run(1);
        start_run(3);
        // A start beyond the node count leaves every node unreachable.
        start_run(15);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            steady = (p == STEADY_PHASE);
            write_node_count(PHASE_COUNTS[p]);
            n = route.active_nodes();
            // Complete the square before any run under this setting.
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    if (!loaded[r][c]) load_weight(r, c, rand_weight());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2) wait_drained();
                if (k == 0 || $urandom_range(99) < 30) begin
                    // Mostly valid starts, some that may lie beyond the count.
                    if ($urandom_range(99) < 85) start_run($urandom_range(n - 1));
                    else start_run($urandom_range(15));
                end else if ($urandom_range(99) < 85) begin
                    load_weight($urandom_range(n - 1), $urandom_range(n - 1), rand_weight());
                end else begin
                    load_weight($urandom_range(15), $urandom_range(15), rand_weight());
                end
            end
        end
        steady = 1'b0;

        // Drain, then give any stray result time to show up.
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (route.errors == 0 && route.expected_results.size() == 0)
            $display("tb_dijkstra_shortest_paths: clean");
        else
            $display("tb_dijkstra_shortest_paths: errors");
        $finish;
    end

endmodule
